/* sv/sst_pkg.sv */
// Package for the sparse set table: sizes, request codes, result codes and the
// memory request structs shared by the sequencer and the top level.
// No dependencies.
`timescale 1ns / 1ps

package sst_pkg;

    localparam int ID_SPACE      = 1024;
    localparam int CAPACITY      = 256;
    localparam int PAYLOAD_WIDTH = 32;

    localparam int OPCODE_W = 2;
    localparam int ID_W     = 10;
    localparam int WDATA_W  = 32;
    localparam int STATUS_W = 3;
    localparam int RDATA_W  = 32;
    localparam int COUNT_W  = 9;

    localparam int MAP_AW  = $clog2(ID_SPACE);
    localparam int SLOT_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int MAP_W   = SLOT_W + 1;
    localparam int DENSE_W = MAP_AW + PAYLOAD_WIDTH;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_GET    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic              we;
        logic [MAP_AW-1:0] waddr;
        logic [MAP_W-1:0]  wdata;
        logic [MAP_AW-1:0] raddr;
    } map_req_t;

    typedef struct packed {
        logic               we;
        logic [SLOT_W-1:0]  waddr;
        logic [DENSE_W-1:0] wdata;
        logic [SLOT_W-1:0]  raddr;
    } dense_req_t;

endpackage

/* sv/sparse_set_table_top.sv */
// Top level of the sparse set table: stream ports, map and dense memories,
// request sequencer and the result register.
// Depends on sst_pkg, sst_ram and sst_seq.
`timescale 1ns / 1ps

// Sparse set of up to 256 elements keyed by a 10-bit id, each with a 32-bit
// payload; delete swaps the last element into the freed slot. After reset the
// block clears the id map and takes no request while it does so. Each request
// then passes through the lookup and result states, with a payload read state
// added for get and a map relink state added for delete; the map and dense
// memories have registered reads. A result waits in an output register, so
// the next request can be taken before it is collected.

module sparse_set_table_top
    import sst_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // opcode [1:0], id [11:2], write_data [43:12], zero [47:44]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // status [2:0], read_data [34:3], count [43:35], zero [47:44]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    map_req_t            map_req;
    dense_req_t          dense_req;
    logic [MAP_W-1:0]    map_rdata;
    logic [DENSE_W-1:0]  dense_rdata;
    logic                res_free;
    logic                res_valid;
    logic [STATUS_W-1:0] res_status;
    logic [RDATA_W-1:0]  res_rdata;
    logic [COUNT_W-1:0]  res_count;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [RDATA_W-1:0]  out_rdata_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    sst_ram #(
        .WIDTH (MAP_W),
        .DEPTH (ID_SPACE)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_req.we),
        .waddr (map_req.waddr),
        .wdata (map_req.wdata),
        .raddr (map_req.raddr),
        .rdata (map_rdata)
    );

    sst_ram #(
        .WIDTH (DENSE_W),
        .DEPTH (CAPACITY)
    ) u_dense_ram (
        .clk   (clk),
        .we    (dense_req.we),
        .waddr (dense_req.waddr),
        .wdata (dense_req.wdata),
        .raddr (dense_req.raddr),
        .rdata (dense_rdata)
    );

    sst_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (s_axis_tvalid),
        .req_ready   (s_axis_tready),
        .req_opcode  (s_axis_tdata[OPCODE_W-1:0]),
        .req_id      (s_axis_tdata[OPCODE_W +: ID_W]),
        .req_wdata   (s_axis_tdata[OPCODE_W + ID_W +: WDATA_W]),
        .map_req     (map_req),
        .map_rdata   (map_rdata),
        .dense_req   (dense_req),
        .dense_rdata (dense_rdata),
        .res_free    (res_free),
        .res_valid   (res_valid),
        .res_status  (res_status),
        .res_rdata   (res_rdata),
        .res_count   (res_count)
    );

    assign res_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_status_reg <= res_status;
            out_rdata_reg  <= res_rdata;
            out_count_reg  <= res_count;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        (OUT_TDATA_W - STATUS_W - RDATA_W - COUNT_W)'(0),
        out_count_reg,
        out_rdata_reg,
        out_status_reg
    };

endmodule

/* sv/sst_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/sst_seq.sv */
// Request sequencer of the sparse set table: map clearing pass, lookup,
// read-modify-write of the map and dense memories, and the element count.
// Depends on sst_pkg.
`timescale 1ns / 1ps

module sst_seq
    import sst_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [OPCODE_W-1:0] req_opcode,
    input  logic [ID_W-1:0]     req_id,
    input  logic [WDATA_W-1:0]  req_wdata,
    output map_req_t            map_req,
    input  logic [MAP_W-1:0]    map_rdata,
    output dense_req_t          dense_req,
    input  logic [DENSE_W-1:0]  dense_rdata,
    input  logic                res_free,
    output logic                res_valid,
    output logic [STATUS_W-1:0] res_status,
    output logic [RDATA_W-1:0]  res_rdata,
    output logic [COUNT_W-1:0]  res_count
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_READ,
        S_DEL2,
        S_RESP
    } state_t;

    state_t              state_reg, state_next;
    logic [MAP_AW-1:0]   clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [OPCODE_W-1:0] op_reg;
    logic [ID_W-1:0]     id_reg;
    logic [WDATA_W-1:0]  wdata_reg;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [MAP_AW-1:0]   moved_id_reg, moved_id_next;
    logic                move_reg, move_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [RDATA_W-1:0]  rdata_reg, rdata_next;

    logic              accept;
    logic              in_range;
    logic              hit;
    logic              full;
    logic [SLOT_W-1:0] map_slot;
    logic [SLOT_W-1:0] last_slot;

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP) && res_free;
    assign res_status = status_reg;
    assign res_rdata  = rdata_reg;
    assign res_count  = COUNT_W'(count_reg);

    assign in_range  = (32'(id_reg) < ID_SPACE) && (op_reg != OP_UNUSED);
    assign hit       = map_rdata[SLOT_W] && in_range;
    assign map_slot  = map_rdata[SLOT_W-1:0];
    assign last_slot = SLOT_W'(count_reg - 1'b1);
    assign full      = (32'(count_reg) >= CAPACITY);

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        count_next    = count_reg;
        slot_next     = slot_reg;
        moved_id_next = moved_id_reg;
        move_next     = move_reg;
        status_next   = status_reg;
        rdata_next    = rdata_reg;

        map_req.we      = 1'b0;
        map_req.waddr   = id_reg[MAP_AW-1:0];
        map_req.wdata   = '0;
        map_req.raddr   = req_id[MAP_AW-1:0];
        dense_req.we    = 1'b0;
        dense_req.waddr = map_slot;
        dense_req.wdata = {id_reg[MAP_AW-1:0], wdata_reg[PAYLOAD_WIDTH-1:0]};
        dense_req.raddr = last_slot;

        unique case (state_reg)
            S_CLEAR:
            begin
                map_req.we    = 1'b1;
                map_req.waddr = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (32'(clr_addr_reg) == ID_SPACE - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                rdata_next = '0;
                slot_next  = map_slot;
                state_next = S_RESP;
                if (!in_range)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else if (op_reg == OP_INSERT)
                begin
                    if (hit)
                    begin
                        dense_req.we = 1'b1;
                        status_next  = ST_UPDATED;
                    end
                    else if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        dense_req.we    = 1'b1;
                        dense_req.waddr = SLOT_W'(count_reg);
                        map_req.we      = 1'b1;
                        map_req.wdata   = {1'b1, SLOT_W'(count_reg)};
                        count_next      = count_reg + 1'b1;
                        status_next     = ST_INSERTED;
                    end
                end
                else if (!hit)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else if (op_reg == OP_GET)
                begin
                    dense_req.raddr = map_slot;
                    status_next     = ST_FOUND;
                    state_next      = S_READ;
                end
                else
                begin
                    // The last dense entry takes the freed slot; its map link
                    // is fixed in the following cycle.
                    move_next       = (map_slot != last_slot);
                    moved_id_next   = dense_rdata[DENSE_W-1 -: MAP_AW];
                    dense_req.we    = (map_slot != last_slot);
                    dense_req.wdata = dense_rdata;
                    map_req.we      = 1'b1;
                    status_next     = ST_DELETED;
                    state_next      = S_DEL2;
                end
            end
            S_READ:
            begin
                rdata_next = RDATA_W'(dense_rdata[PAYLOAD_WIDTH-1:0]);
                state_next = S_RESP;
            end
            S_DEL2:
            begin
                map_req.we    = move_reg;
                map_req.waddr = moved_id_reg;
                map_req.wdata = {1'b1, slot_reg};
                count_next    = count_reg - 1'b1;
                state_next    = S_RESP;
            end
            S_RESP:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            count_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= req_opcode;
            id_reg    <= req_id;
            wdata_reg <= req_wdata;
        end
        slot_reg     <= slot_next;
        moved_id_reg <= moved_id_next;
        move_reg     <= move_next;
        status_reg   <= status_next;
        rdata_reg    <= rdata_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= CAPACITY)
        else $error("element count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |->
            (count_reg == $past(count_reg) + 1'b1) || (count_reg == $past(count_reg) - 1'b1))
        else $error("element count moved by more than one");

    a_clear_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (map_req.we && (map_req.wdata == '0)))
        else $error("map clearing pass skipped an entry");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !req_ready)
        else $error("request taken during clearing pass");

    a_relink_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEL2 && move_reg) |-> (map_req.we && map_req.wdata[SLOT_W]))
        else $error("moved entry lost its map link");
`endif

endmodule

/* bench/tb.sv */
// Self-checking bench for sparse_set_table_top: a queued stream driver, a
// result monitor and a behavioral copy of the sparse set that predicts each result.
// Depends on sst_pkg and the sparse_set_table_top RTL.
`timescale 1ns / 1ps

module tb;
    import sst_pkg::*;

    localparam int RUN_LIMIT_NS = 1000000;
    localparam int TAIL_CYCLES  = 20;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [ID_W-1:0]     id;
        logic [WDATA_W-1:0]  wdata;
    } table_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RDATA_W-1:0]  rdata;
        logic [COUNT_W-1:0]  count;
    } table_resp_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    sparse_set_table_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    table_req_t  pending_req[$];
    table_resp_t expected_resp[$];
    int          error_count = 0;

    // Shadow copy of the table used for prediction.
    bit                  sh_mapped [ID_SPACE];
    logic [SLOT_W-1:0]   sh_slot   [ID_SPACE];
    logic [ID_W-1:0]     sh_slot_id[CAPACITY];
    logic [RDATA_W-1:0]  sh_payload[CAPACITY];
    int                  sh_count = 0;

    // Occupancy as seen by the stimulus generator.
    bit              gen_present[ID_SPACE];
    logic [ID_W-1:0] gen_ids[$];

    function automatic table_resp_t predict_table_op(table_req_t rq);
        table_resp_t rs;
        int          slot;
        int          last;
        logic [ID_W-1:0] moved;
        begin
            rs.status = ST_NOT_FOUND;
            rs.rdata  = '0;
            if (rq.op == OP_INSERT)
            begin
                if (sh_mapped[rq.id])
                begin
                    sh_payload[sh_slot[rq.id]] = rq.wdata;
                    rs.status = ST_UPDATED;
                end
                else if (sh_count >= CAPACITY)
                begin
                    rs.status = ST_FULL;
                end
                else
                begin
                    sh_slot_id[sh_count] = rq.id;
                    sh_payload[sh_count] = rq.wdata;
                    sh_slot[rq.id]       = sh_count[SLOT_W-1:0];
                    sh_mapped[rq.id]     = 1'b1;
                    sh_count++;
                    rs.status = ST_INSERTED;
                end
            end
            else if ((rq.op == OP_GET || rq.op == OP_DELETE) && sh_mapped[rq.id])
            begin
                slot = int'(sh_slot[rq.id]);
                if (rq.op == OP_GET)
                begin
                    rs.status = ST_FOUND;
                    rs.rdata  = sh_payload[slot];
                end
                else
                begin
                    last = sh_count - 1;
                    if (slot != last)
                    begin
                        moved            = sh_slot_id[last];
                        sh_payload[slot] = sh_payload[last];
                        sh_slot_id[slot] = moved;
                        sh_slot[moved]   = slot[SLOT_W-1:0];
                    end
                    sh_count--;
                    sh_mapped[rq.id] = 1'b0;
                    rs.status = ST_DELETED;
                end
            end
            rs.count = sh_count[COUNT_W-1:0];
            return rs;
        end
    endfunction

    function automatic int pick_idle_len(bit calm);
        int r;
        begin
            r = $urandom_range(0, 99);
            if (calm || r < 55)
                return 0;
            else if (r < 92)
                return $urandom_range(1, 3);
            else
                return $urandom_range(10, 40);
        end
    endfunction

    task automatic queue_request(logic [OPCODE_W-1:0] op, logic [ID_W-1:0] id,
                                 logic [WDATA_W-1:0] wdata);
        table_req_t rq;
        int         idx;
        begin
            rq.op    = op;
            rq.id    = id;
            rq.wdata = wdata;
            pending_req.push_back(rq);
            if (op == OP_INSERT && !gen_present[id] && gen_ids.size() < CAPACITY)
            begin
                gen_present[id] = 1'b1;
                gen_ids.push_back(id);
            end
            else if (op == OP_DELETE && gen_present[id])
            begin
                gen_present[id] = 1'b0;
                for (idx = 0; idx < gen_ids.size(); idx++)
                begin
                    if (gen_ids[idx] == id)
                    begin
                        gen_ids.delete(idx);
                        break;
                    end
                end
            end
        end
    endtask

    function automatic logic [ID_W-1:0] present_id();
        return gen_ids[$urandom_range(0, gen_ids.size() - 1)];
    endfunction

    function automatic logic [ID_W-1:0] absent_id();
        logic [ID_W-1:0] id;
        begin
            do
                id = ID_W'($urandom_range(0, ID_SPACE - 1));
            while (gen_present[id]);
            return id;
        end
    endfunction

    function automatic logic [WDATA_W-1:0] random_payload();
        int r;
        begin
            r = $urandom_range(0, 7);
            if (r == 0)
                return '0;
            else if (r == 1)
                return '1;
            else
                return $urandom;
        end
    endfunction

    task automatic queue_mixed_request();
        int              r;
        int              s;
        logic [OPCODE_W-1:0] op;
        logic [ID_W-1:0] id;
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                op = OP_INSERT;
            else if (r < 70)
                op = OP_GET;
            else if (r < 95)
                op = OP_DELETE;
            else
                op = OP_UNUSED;
            s = $urandom_range(0, 3);
            if (s < 2 && gen_ids.size() > 0)
                id = present_id();
            else if (s == 2)
                id = ID_W'($urandom_range(0, 31));
            else
                id = ID_W'($urandom_range(0, ID_SPACE - 1));
            queue_request(op, id, random_payload());
        end
    endtask

    // Request driver.
    int  drv_gap;
    int  drv_cyc;
    bit  drv_fire;
    bit  drv_valid;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            drv_gap = 0;
            drv_cyc = 0;
        end
        else
        begin
            drv_cyc++;
            drv_fire = s_axis_tvalid && s_axis_tready;
            if (drv_fire)
            begin
                expected_resp.push_back(predict_table_op(pending_req[0]));
                pending_req.pop_front();
                drv_gap = pick_idle_len(drv_cyc[9] & drv_cyc[8]);
            end
            if (s_axis_tvalid && !drv_fire)
                drv_valid = 1'b1;
            else if (drv_gap > 0)
            begin
                drv_gap--;
                drv_valid = 1'b0;
            end
            else
                drv_valid = pending_req.size() != 0;
            s_axis_tvalid <= drv_valid;
            if (drv_valid)
                s_axis_tdata <= {4'b0, pending_req[0].wdata, pending_req[0].id,
                                 pending_req[0].op};
        end
    end

    // Long receiver hold-off, started on two chosen requests.
    bit hold_off = 1'b0;
    int hold_left;
    int hold_seen;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off <= 1'b0;
            hold_left = 0;
            hold_seen = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                hold_seen++;
                if (hold_seen == 60 || hold_seen == 420)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
                hold_left--;
            hold_off <= hold_left != 0;
        end
    end

    // Result monitor.
    int          mon_stall;
    int          mon_cyc;
    table_resp_t mon_exp;
    table_resp_t mon_got;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            mon_stall = 0;
            mon_cyc   = 0;
        end
        else
        begin
            mon_cyc++;
            if (m_axis_tvalid && m_axis_tready)
            begin
                mon_got.status = m_axis_tdata[2:0];
                mon_got.rdata  = m_axis_tdata[34:3];
                mon_got.count  = m_axis_tdata[43:35];
                if (expected_resp.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %h", $time, mon_got);
                    error_count++;
                end
                else
                begin
                    mon_exp = expected_resp.pop_front();
                    if (mon_got.status !== mon_exp.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, mon_exp.status, mon_got.status);
                        error_count++;
                    end
                    if (mon_got.rdata !== mon_exp.rdata)
                    begin
                        $display("%0t: read_data mismatch, expected %h, actual %h",
                                 $time, mon_exp.rdata, mon_got.rdata);
                        error_count++;
                    end
                    if (mon_got.count !== mon_exp.count)
                    begin
                        $display("%0t: count mismatch, expected %0d, actual %0d",
                                 $time, mon_exp.count, mon_got.count);
                        error_count++;
                    end
                end
            end
            if (mon_stall > 0)
                mon_stall--;
            else if ($urandom_range(0, 3) == 0)
                mon_stall = pick_idle_len(mon_cyc[9] & ~mon_cyc[8]);
            m_axis_tready <= !hold_off && mon_stall == 0;
        end
    end

    initial
    begin
        int i;
        int r;

        // Directed requests.
        queue_request(OP_GET, 10'd0, '0);
        queue_request(OP_DELETE, 10'd1023, '1);
        queue_request(OP_UNUSED, 10'd5, 32'h1234_5678);
        queue_request(OP_INSERT, 10'd0, 32'h0000_0000);
        queue_request(OP_INSERT, 10'd1023, 32'hFFFF_FFFF);
        queue_request(OP_INSERT, 10'd512, 32'hA5A5_A5A5);
        queue_request(OP_INSERT, 10'd0, 32'h5A5A_5A5A);
        queue_request(OP_GET, 10'd0, '1);
        queue_request(OP_GET, 10'd1023, '0);
        queue_request(OP_GET, 10'd512, '0);
        queue_request(OP_DELETE, 10'd0, '0);
        queue_request(OP_GET, 10'd512, '0);
        queue_request(OP_GET, 10'd0, '0);
        queue_request(OP_DELETE, 10'd0, '0);
        queue_request(OP_DELETE, 10'd1023, '0);
        queue_request(OP_GET, 10'd1023, '0);
        queue_request(OP_DELETE, 10'd512, '0);
        queue_request(OP_GET, 10'd512, '0);
        queue_request(OP_UNUSED, 10'd1023, '1);
        queue_request(OP_INSERT, 10'd341, 32'h8000_0001);
        queue_request(OP_UNUSED, 10'd341, '0);
        queue_request(OP_GET, 10'd341, '0);

        // Random mix on a mostly empty table.
        for (i = 0; i < 60; i++)
            queue_mixed_request();

        // Fill to capacity with occasional reads.
        while (gen_ids.size() < CAPACITY)
        begin
            if ($urandom_range(0, 99) < 85)
                queue_request(OP_INSERT, absent_id(), random_payload());
            else
                queue_request(OP_GET, present_id(), random_payload());
        end

        // Full table: new ids are rejected, updates still land.
        for (i = 0; i < 24; i++)
        begin
            r = $urandom_range(0, 3);
            if (r == 0)
                queue_request(OP_INSERT, absent_id(), random_payload());
            else if (r == 1)
                queue_request(OP_INSERT, present_id(), random_payload());
            else if (r == 2)
                queue_request(OP_GET, present_id(), random_payload());
            else
                queue_request(OP_UNUSED, present_id(), random_payload());
        end

        // Drain with swap-remove deletes.
        for (i = 0; i < 120; i++)
        begin
            r = $urandom_range(0, 99);
            if (gen_ids.size() == 0)
                queue_mixed_request();
            else if (r < 60)
                queue_request(OP_DELETE, present_id(), random_payload());
            else if (r < 80)
                queue_request(OP_GET, ID_W'($urandom_range(0, ID_SPACE - 1)),
                              random_payload());
            else if (r < 90)
                queue_request(OP_GET, present_id(), random_payload());
            else
                queue_request(OP_INSERT, present_id(), random_payload());
        end

        for (i = 0; i < 40; i++)
            queue_mixed_request();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_req.size() != 0 || expected_resp.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("%0t: timeout", $time);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
